FILE: sv/tes_pkg.sv
// Shared types and constants for the timer expiry scheduler.
package tes_pkg;

   localparam logic [2:0] OP_ARM_ONCE = 3'd0;
   localparam logic [2:0] OP_ARM_PERIODIC = 3'd1;
   localparam logic [2:0] OP_FIRE_NOW = 3'd2;
   localparam logic [2:0] OP_CANCEL = 3'd3;
   localparam logic [2:0] OP_TICK = 3'd4;

   localparam logic [1:0] KIND_ASSIGNED = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_REJECTED = 2'd2;

   localparam int MAX_FIRES = 16;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] delay_ms;
      logic [31:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] timer_id;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIRE,
      ST_EMIT1,
      ST_EMIT2
   } state_type;

endpackage

FILE: sv/tes_if.sv
// Valid/ready channel interface for request and response transactions.
interface tes_req_if;
   logic              valid;
   logic              ready;
   tes_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tes_rsp_if;
   logic              valid;
   logic              ready;
   tes_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/timer_expiry_scheduler.sv
// Top level of the timer expiry scheduler.
//  channel | dir | transaction
//  req     | in  | op, delay_ms, cancel_id
//  rsp     | out | kind, timer_id, last
//  csr     | in  | enabled write
// Arm, fire and cancel are taken from idle; a tick runs one serial slot-scan pass
// per fired timer, plus a final pass when fewer than MAX_FIRES timers fire.
// Reset is synchronous; all timers are dropped and ids restart at one.
// A stalled response holds the back end; the front queue holds two requests.
module timer_expiry_scheduler #(
   parameter int NUM_TIMERS = 16
) (
   input  logic  clock,
   input  logic  reset,
   input  logic  csr_we,
   input  logic  csr_wdata,
   tes_req_if.sink   req,
   tes_rsp_if.source rsp
);

   logic enabled_ff;
   logic cmd_valid, cmd_take;
   tes_pkg::req_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_we) begin
         enabled_ff <= csr_wdata;
      end
   end

   tes_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
   );

   tes_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock(clock), .reset(reset), .enabled(enabled_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take), .rsp(rsp)
   );

endmodule

FILE: sv/tes_front.sv
// Front end: request intake into a two-entry command queue.
module tes_front (
   input  logic               clock,
   input  logic               reset,
   tes_req_if.sink            req,
   output logic               cmd_valid,
   output tes_pkg::req_type   cmd,
   input  logic               cmd_take
);

   tes_pkg::req_type q_ff [2];
   tes_pkg::req_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready
      && (req.payload.op == tes_pkg::OP_ARM_ONCE || req.payload.op == tes_pkg::OP_ARM_PERIODIC
       || req.payload.op == tes_pkg::OP_FIRE_NOW || req.payload.op == tes_pkg::OP_CANCEL
       || req.payload.op == tes_pkg::OP_TICK);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (cmd_take && cmd_valid) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = req.payload;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: sv/tes_back.sv
// Back end: timer store, id allocation, expiry scan and response output.
module tes_back #(
   parameter int NUM_TIMERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enabled,
   input  logic               cmd_valid,
   input  tes_pkg::req_type   cmd,
   output logic               cmd_take,
   tes_rsp_if.source          rsp
);

   localparam int IW = $clog2(NUM_TIMERS);
   localparam int FW = $clog2(tes_pkg::MAX_FIRES + 1);

   logic [NUM_TIMERS-1:0] live_ff, live_in, chosen_ff, chosen_in;
   logic [31:0] ident_ff [NUM_TIMERS];
   logic [31:0] due_ff [NUM_TIMERS];
   logic [15:0] period_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] periodic_ff;
   logic [31:0] next_id_ff, next_id_in, now_ff, now_in;
   tes_pkg::state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic found_ff, found_in;
   logic [31:0] best_od_ff, best_od_in, best_id_ff, best_id_in;
   logic [FW-1:0] nfire_ff, nfire_in;
   logic [31:0] hold_id_ff, hold_id_in;
   logic pend_ff, pend_in;
   tes_pkg::rsp_type pend_data_ff, pend_data_in;
   logic out_valid_ff, out_valid_in;
   tes_pkg::rsp_type out_ff, out_in;

   logic [31:0] od;
   logic cand, out_free, wr_slot, fire_slot;
   logic [IW-1:0] free_idx;
   logic has_free;
   logic [15:0] per1;

   assign out_free = !out_valid_ff || rsp.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;
   assign od = now_ff - due_ff[idx_ff];
   assign cand = live_ff[idx_ff] && !chosen_ff[idx_ff] && !od[31];
   assign per1 = (period_ff[best_ff] == 16'd0) ? 16'd1 : period_ff[best_ff];

   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            has_free = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tes_pkg::ST_IDLE: begin
            if (cmd_valid && out_free && !pend_ff) begin
               if (cmd.op == tes_pkg::OP_TICK) begin
                  state_in = tes_pkg::ST_SCAN;
               end else if (cmd.op == tes_pkg::OP_FIRE_NOW && enabled) begin
                  state_in = tes_pkg::ST_EMIT2;
               end
            end
         end
         tes_pkg::ST_SCAN: begin
            if (idx_ff == IW'(NUM_TIMERS - 1)) begin
               state_in = tes_pkg::ST_FIRE;
            end
         end
         tes_pkg::ST_FIRE: begin
            if (!found_ff) begin
               state_in = tes_pkg::ST_EMIT1;
            end else if (out_free) begin
               state_in = tes_pkg::ST_SCAN;
            end
         end
         tes_pkg::ST_EMIT1: begin
            if (out_free) begin
               state_in = tes_pkg::ST_IDLE;
            end
         end
         tes_pkg::ST_EMIT2: begin
            if (out_free) begin
               state_in = tes_pkg::ST_IDLE;
            end
         end
         default: state_in = tes_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      live_in = live_ff;
      chosen_in = chosen_ff;
      next_id_in = next_id_ff;
      now_in = now_ff;
      idx_in = idx_ff;
      best_in = best_ff;
      found_in = found_ff;
      best_od_in = best_od_ff;
      best_id_in = best_id_ff;
      nfire_in = nfire_ff;
      hold_id_in = hold_id_ff;
      pend_in = pend_ff;
      pend_data_in = pend_data_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in = out_ff;
      cmd_take = 1'b0;
      wr_slot = 1'b0;
      fire_slot = 1'b0;
      case (state_ff)
         tes_pkg::ST_IDLE: begin
            if (cmd_valid && out_free && !pend_ff) begin
               cmd_take = 1'b1;
               case (cmd.op)
                  tes_pkg::OP_ARM_ONCE, tes_pkg::OP_ARM_PERIODIC: begin
                     out_valid_in = 1'b1;
                     out_in.last = 1'b1;
                     if (enabled && has_free) begin
                        wr_slot = 1'b1;
                        live_in[free_idx] = 1'b1;
                        out_in.kind = tes_pkg::KIND_ASSIGNED;
                        out_in.timer_id = next_id_ff;
                        next_id_in = (next_id_ff == 32'hFFFF_FFFF) ? 32'd1 : next_id_ff + 32'd1;
                     end else begin
                        out_in.kind = tes_pkg::KIND_REJECTED;
                        out_in.timer_id = '0;
                     end
                  end
                  tes_pkg::OP_FIRE_NOW: begin
                     out_valid_in = 1'b1;
                     if (enabled) begin
                        out_in.kind = tes_pkg::KIND_ASSIGNED;
                        out_in.timer_id = next_id_ff;
                        out_in.last = 1'b0;
                        hold_id_in = next_id_ff;
                        next_id_in = (next_id_ff == 32'hFFFF_FFFF) ? 32'd1 : next_id_ff + 32'd1;
                     end else begin
                        out_in.kind = tes_pkg::KIND_REJECTED;
                        out_in.timer_id = '0;
                        out_in.last = 1'b1;
                     end
                  end
                  tes_pkg::OP_CANCEL: begin
                     for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (live_ff[i] && ident_ff[i] == cmd.cancel_id) begin
                           live_in[i] = 1'b0;
                        end
                     end
                  end
                  tes_pkg::OP_TICK: begin
                     now_in = now_ff + 32'd1;
                     chosen_in = '0;
                     nfire_in = '0;
                     idx_in = '0;
                     found_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tes_pkg::ST_SCAN: begin
            if (cand && (!found_ff || od > best_od_ff
                  || (od == best_od_ff && ident_ff[idx_ff] < best_id_ff))) begin
               found_in = 1'b1;
               best_in = idx_ff;
               best_od_in = od;
               best_id_in = ident_ff[idx_ff];
            end
            idx_in = (idx_ff == IW'(NUM_TIMERS - 1)) ? '0 : idx_ff + IW'(1);
         end
         tes_pkg::ST_FIRE: begin
            if (found_ff && out_free) begin
               fire_slot = 1'b1;
               chosen_in[best_ff] = 1'b1;
               if (!periodic_ff[best_ff]) begin
                  live_in[best_ff] = 1'b0;
               end
               if (pend_ff) begin
                  out_valid_in = 1'b1;
                  out_in = pend_data_ff;
               end
               pend_in = 1'b1;
               pend_data_in.kind = tes_pkg::KIND_FIRED;
               pend_data_in.timer_id = best_id_ff;
               pend_data_in.last = 1'b0;
               nfire_in = nfire_ff + FW'(1);
               found_in = 1'b0;
               idx_in = '0;
            end
         end
         tes_pkg::ST_EMIT1: begin
            if (out_free) begin
               if (pend_ff) begin
                  out_valid_in = 1'b1;
                  out_in = pend_data_ff;
                  out_in.last = 1'b1;
               end
               pend_in = 1'b0;
            end
         end
         tes_pkg::ST_EMIT2: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.kind = tes_pkg::KIND_FIRED;
               out_in.timer_id = hold_id_ff;
               out_in.last = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (state_ff == tes_pkg::ST_FIRE && found_ff && out_free
            && nfire_ff == FW'(tes_pkg::MAX_FIRES - 1)) begin
         found_in = 1'b0;
      end
   end

   logic stop_ff;
   always_ff @(posedge clock) begin
      if (wr_slot) begin
         ident_ff[free_idx] <= next_id_ff;
         due_ff[free_idx] <= now_ff + {16'd0, cmd.delay_ms};
         period_ff[free_idx] <= cmd.delay_ms;
         periodic_ff[free_idx] <= (cmd.op == tes_pkg::OP_ARM_PERIODIC);
      end
      if (fire_slot) begin
         due_ff[best_ff] <= now_ff + {16'd0, per1};
      end
      idx_ff <= idx_in;
      best_ff <= best_in;
      best_od_ff <= best_od_in;
      best_id_ff <= best_id_in;
      hold_id_ff <= hold_id_in;
      pend_data_ff <= pend_data_in;
      out_ff <= out_in;
      chosen_ff <= chosen_in;
      nfire_ff <= nfire_in;
      if (reset) begin
         state_ff <= tes_pkg::ST_IDLE;
         live_ff <= '0;
         next_id_ff <= 32'd1;
         now_ff <= '0;
         found_ff <= 1'b0;
         pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         next_id_ff <= next_id_in;
         now_ff <= now_in;
         out_valid_ff <= out_valid_in;
         pend_ff <= pend_in;
         stop_ff <= (state_ff == tes_pkg::ST_FIRE && found_ff && out_free
            && nfire_ff == FW'(tes_pkg::MAX_FIRES - 1));
         if (stop_ff) begin
            state_ff <= tes_pkg::ST_EMIT1;
            found_ff <= 1'b0;
         end else begin
            state_ff <= state_in;
            found_ff <= found_in;
         end
      end
   end

endmodule
